@@ rtl/gspc_pkg.sv @@
// Shared constants, types and functions for the gas sensor ppm converter.
`default_nettype none
package gspc_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 24;
	localparam int RES_W           = 16;
	localparam int SCALE_W         = 24;
	localparam int EXP_W           = 16;
	localparam int CONC_W          = 32;

	localparam logic [CFG_IDX_W-1:0] REG_LOAD_GAS    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAN_GAS   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAS   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_GAS     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOAD_SMOKE  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAN_SMOKE = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_SMOKE = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_SMOKE   = 4'd7;

	localparam logic [RES_W-1:0]   RST_LOAD_GAS    = 16'd10035;
	localparam logic [RES_W-1:0]   RST_CLEAN_GAS   = 16'd5407;
	localparam logic [SCALE_W-1:0] RST_SCALE_GAS   = 24'd129229;
	localparam logic [EXP_W-1:0]   RST_EXP_GAS     = 16'hD3F0;
	localparam logic [RES_W-1:0]   RST_LOAD_SMOKE  = 16'd1004;
	localparam logic [RES_W-1:0]   RST_CLEAN_SMOKE = 16'd2888;
	localparam logic [SCALE_W-1:0] RST_SCALE_SMOKE = 24'd824320;
	localparam logic [EXP_W-1:0]   RST_EXP_SMOKE   = 16'hDC83;

	typedef struct packed {
		logic                    spec;
		logic [CONC_W-1:0]       conc;
		logic                    sat;
		logic                    inv;
		logic signed [EXP_W-1:0] e;
	} side_t;

	// 2^(2^-(j+1)) in Q30, by repeated truncated square roots from 2.0
	function automatic logic [31:0] exp2_root(input int j);
		longint unsigned f;
		longint unsigned x;
		longint unsigned r;
		longint unsigned b;
		int n;
		int i;
		f = 64'd1 << 31;
		for (n = 0; n <= j; n++) begin
			x = f << 30;
			r = 0;
			b = 64'd1 << 62;
			for (i = 0; i < 32; i++) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			f = r;
		end
		return f[31:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/gspc_log2.sv @@
// Pipelined base-2 logarithm, Q16 result, one squaring per stage.
`default_nettype none
module gspc_log2 import gspc_pkg::*; #(
	parameter int IW = 41
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [IW-1:0]              x,
	output logic      [$clog2(IW)+15:0]     l
);
	localparam int PW = $clog2(IW);

	logic [PW-1:0]     p_w;
	logic [IW+15:0]    ext_w;
	logic [16:0]       m_s [0:16];
	logic [PW-1:0]     p_s [0:16];
	logic [15:0]       f_s [0:16];

	always_comb begin
		p_w = '0;
		for (int i = 0; i < IW; i++) begin
			if (x[i]) p_w = PW'(i);
		end
		ext_w = {x, 16'b0} >> p_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= ext_w[16:0];
			p_s[0] <= p_w;
			f_s[0] <= '0;
		end
	end

	for (genvar g = 0; g < 16; g++) begin : g_sq
		logic [33:0] sq;
		assign sq = 34'(m_s[g]) * 34'(m_s[g]);
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[g+1] <= sq[33] ? sq[33:17] : sq[32:16];
				f_s[g+1] <= f_s[g] | (sq[33] ? (16'd1 << (15 - g)) : 16'd0);
				p_s[g+1] <= p_s[g];
			end
		end
	end

	assign l = {p_s[16], f_s[16]};
endmodule
`default_nettype wire

@@ rtl/gspc_exp2.sv @@
// Pipelined 2^frac in Q30, one conditional root multiply per stage.
`default_nettype none
module gspc_exp2 import gspc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [15:0] fp,
	output logic      [31:0] acc
);
	logic [31:0] acc_s [0:16];
	logic [15:0] fp_s  [0:16];

	assign acc_s[0] = 32'd1 << 30;
	assign fp_s[0]  = fp;

	for (genvar g = 0; g < 16; g++) begin : g_mul
		localparam logic [31:0] ROOT = exp2_root(g);
		logic [63:0] pr;
		assign pr = 64'(acc_s[g]) * 64'(ROOT);
		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[g+1] <= fp_s[g][15-g] ? pr[61:30] : acc_s[g];
				fp_s[g+1]  <= fp_s[g];
			end
		end
	end

	assign acc = acc_s[16];
endmodule
`default_nettype wire

@@ rtl/gas_sensor_ppm_converter.sv @@
// Top level of the gas sensor ppm converter.
// Converts one signed ADC sample per cycle into ppm (Q24.8) through a 39-stage
// pipeline: front end (voltage clamp, resistance products), three 17-stage
// log2 units for numerator, denominator and scale, exponent multiply, and a
// 16-stage exp2 unit. One transaction per cycle is accepted whenever the
// output stage is empty or being taken. Configuration
// writes are always accepted and should only be made while the pipe is empty.
`default_nettype none
module gas_sensor_ppm_converter import gspc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // raw_sample
	input  wire logic                             s_tuser,  // kind
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [CONC_W-1:0]                m_tdata,  // concentration
	output logic      [1:0]                       m_tuser,  // invalid, saturated
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]             cfg_index,
	input  wire logic [CFG_DATA_W-1:0]            cfg_data
);
	localparam int SB    = SAMPLE_BITS;
	localparam int VW    = SB + 2;
	localparam int DW    = SB + 1;
	localparam int NW    = RES_W + DW;
	localparam int LWN   = $clog2(NW) + 16;
	localparam int LWS   = $clog2(SCALE_W) + 16;
	localparam int LRW   = LWN + 1;
	localparam int PRW   = EXP_W + LRW;
	localparam int TW    = PRW - 11;
	localparam int IPW   = TW - 16;
	localparam int LOG_L = 17;
	localparam int EXP_L = 16;
	localparam int DEPTH = 2 + LOG_L + 3 + EXP_L + 1;

	localparam logic [DW-1:0]        SUPPLY  = DW'(5000 << (SB - 12));
	localparam logic signed [VW-1:0] FLOOR_V = VW'(50 << (SB - 12));
	localparam logic signed [TW-1:0] T_MAX   = TW'(32 * 65536);

	logic [RES_W-1:0]   load_gas_q, clean_gas_q, load_smoke_q, clean_smoke_q;
	logic [SCALE_W-1:0] scale_gas_q, scale_smoke_q;
	logic [EXP_W-1:0]   exp_gas_q, exp_smoke_q;
	logic [DEPTH-1:0]   vld_q;
	logic               en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_gas_q    <= RST_LOAD_GAS;
			clean_gas_q   <= RST_CLEAN_GAS;
			scale_gas_q   <= RST_SCALE_GAS;
			exp_gas_q     <= RST_EXP_GAS;
			load_smoke_q  <= RST_LOAD_SMOKE;
			clean_smoke_q <= RST_CLEAN_SMOKE;
			scale_smoke_q <= RST_SCALE_SMOKE;
			exp_smoke_q   <= RST_EXP_SMOKE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LOAD_GAS:    load_gas_q    <= cfg_data[RES_W-1:0];
				REG_CLEAN_GAS:   clean_gas_q   <= cfg_data[RES_W-1:0];
				REG_SCALE_GAS:   scale_gas_q   <= cfg_data;
				REG_EXP_GAS:     exp_gas_q     <= cfg_data[EXP_W-1:0];
				REG_LOAD_SMOKE:  load_smoke_q  <= cfg_data[RES_W-1:0];
				REG_CLEAN_SMOKE: clean_smoke_q <= cfg_data[RES_W-1:0];
				REG_SCALE_SMOKE: scale_smoke_q <= cfg_data;
				REG_EXP_SMOKE:   exp_smoke_q   <= cfg_data[EXP_W-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !vld_q[DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	// stage 1: voltage, clamp, supply check, channel select
	logic signed [SB-1:0] raw_w;
	logic signed [VW-1:0] v3_w, vc_w;
	logic                 over_w;

	always_comb begin
		raw_w  = $signed(s_tdata[SB-1:0]);
		v3_w   = $signed({raw_w[SB-1], raw_w, 1'b0}) + $signed({{2{raw_w[SB-1]}}, raw_w});
		vc_w   = (v3_w < FLOOR_V) ? FLOOR_V : v3_w;
		over_w = vc_w > $signed({1'b0, SUPPLY});
	end

	logic [RES_W-1:0]        rl_s1, r0_s1;
	logic [SCALE_W-1:0]      scale_s1;
	logic signed [EXP_W-1:0] e_s1;
	logic [DW-1:0]           diff_s1, v_s1;
	logic                    inv_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			rl_s1    <= s_tuser ? load_smoke_q : load_gas_q;
			r0_s1    <= s_tuser ? clean_smoke_q : clean_gas_q;
			scale_s1 <= s_tuser ? scale_smoke_q : scale_gas_q;
			e_s1     <= $signed(s_tuser ? exp_smoke_q : exp_gas_q);
			diff_s1  <= SUPPLY - vc_w[DW-1:0];
			v_s1     <= vc_w[DW-1:0];
			inv_s1   <= over_w;
		end
	end

	// stage 2: ratio numerator and denominator
	logic [NW-1:0]           num_s2, den_s2;
	logic [SCALE_W-1:0]      scale_s2;
	logic signed [EXP_W-1:0] e_s2;
	logic                    inv_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2   <= NW'(rl_s1) * NW'(diff_s1);
			den_s2   <= NW'(v_s1) * NW'(r0_s1);
			scale_s2 <= scale_s1;
			e_s2     <= e_s1;
			inv_s2   <= inv_s1;
		end
	end

	// special cases, carried alongside the log units
	logic [NW+3:0] den9_w;
	logic          big_w, nz_w;
	side_t         side_w;

	always_comb begin
		den9_w = (NW+4)'({den_s2, 3'b000}) + (NW+4)'(den_s2);
		big_w  = ((NW+4)'(num_s2) >= den9_w) || (scale_s2 == '0);
		nz_w   = (num_s2 == '0);
		side_w.e    = e_s2;
		side_w.inv  = inv_s2;
		side_w.sat  = 1'b0;
		side_w.spec = inv_s2 || big_w || nz_w;
		side_w.conc = '0;
		if (!inv_s2 && !big_w && nz_w) begin
			if (e_s2 < 0) begin
				side_w.conc = '1;
				side_w.sat  = 1'b1;
			end else if (e_s2 == 0) begin
				side_w.conc = CONC_W'(scale_s2);
			end
		end
	end

	side_t sd_q [0:LOG_L-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sd_q[0] <= side_w;
			for (int i = 1; i < LOG_L; i++) sd_q[i] <= sd_q[i-1];
		end
	end

	logic [LWN-1:0] ln_w, ld_w;
	logic [LWS-1:0] ls_w;

	gspc_log2 #(.IW(NW)) u_log_num (.clk(clk), .en(en), .x(num_s2), .l(ln_w));
	gspc_log2 #(.IW(NW)) u_log_den (.clk(clk), .en(en), .x(den_s2), .l(ld_w));
	gspc_log2 #(.IW(SCALE_W)) u_log_scale (.clk(clk), .en(en), .x(scale_s2), .l(ls_w));

	// log ratio, exponent product, exponent sum
	logic signed [LRW-1:0] lr_s3;
	logic [LWS-1:0]        ls_s3, ls_s4;
	side_t                 sd_s3, sd_s4, sd_s5;
	logic signed [PRW-1:0] prod_s4;
	logic signed [TW-1:0]  t_w;
	side_t                 side5_w;
	logic [15:0]           fp_s5;
	logic signed [IPW-1:0] ip_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			lr_s3   <= $signed({1'b0, ln_w}) - $signed({1'b0, ld_w});
			ls_s3   <= ls_w;
			sd_s3   <= sd_q[LOG_L-1];
			prod_s4 <= PRW'($signed(sd_s3.e)) * PRW'(lr_s3);
			ls_s4   <= ls_s3;
			sd_s4   <= sd_s3;
		end
	end

	always_comb begin
		t_w     = TW'($signed(prod_s4[PRW-1:12])) + $signed(TW'(ls_s4));
		side5_w = sd_s4;
		if (!sd_s4.spec && t_w >= T_MAX) begin
			side5_w.spec = 1'b1;
			side5_w.conc = '1;
			side5_w.sat  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s5 <= side5_w;
			fp_s5 <= t_w[15:0];
			ip_s5 <= t_w[TW-1:16];
		end
	end

	logic [31:0]           acc_w;
	side_t                 sx_q [0:EXP_L-1];
	logic signed [IPW-1:0] ipx_q [0:EXP_L-1];

	gspc_exp2 u_exp2 (.clk(clk), .en(en), .fp(fp_s5), .acc(acc_w));

	always_ff @(posedge clk) begin
		if (en) begin
			sx_q[0]  <= sd_s5;
			ipx_q[0] <= ip_s5;
			for (int i = 1; i < EXP_L; i++) begin
				sx_q[i]  <= sx_q[i-1];
				ipx_q[i] <= ipx_q[i-1];
			end
		end
	end

	// integer part shift and result select
	logic signed [IPW-1:0] ip_w;
	logic signed [IPW:0]   sh_w;
	logic [CONC_W-1:0]     conc_w;
	side_t                 sf_w;

	always_comb begin
		sf_w = sx_q[EXP_L-1];
		ip_w = ipx_q[EXP_L-1];
		sh_w = $signed((IPW+1)'(30)) - (IPW+1)'(ip_w);
		if (ip_w >= $signed(IPW'(31)))
			conc_w = {acc_w[30:0], 1'b0};
		else if (ip_w == $signed(IPW'(30)))
			conc_w = acc_w;
		else if (sh_w >= $signed((IPW+1)'(32)))
			conc_w = '0;
		else
			conc_w = acc_w >> sh_w[4:0];
		if (sf_w.spec) conc_w = sf_w.conc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= conc_w;
			m_tuser <= {sf_w.inv, sf_w.sat};
		end
	end
endmodule
`default_nettype wire
